[design/rpd_pkg.sv]
// Package: widths, CORDIC constants and arctangent table for the disk sampler.
package rpd_pkg;

    localparam int DrawBitsDef  = 16;
    localparam int CordicSteps  = 24;
    localparam int StepBits     = 5;
    localparam int RootBits     = 32;
    localparam int VecBits      = 52;   // Q16.24 vector plus growth headroom
    localparam int ZBits        = 34;
    localparam logic [31:0] CordicGain = 32'd2608131496;

    // Register byte addresses (index times four)
    localparam logic [3:0] AddrRadius  = 4'd0;
    localparam logic [3:0] AddrCenterX = 4'd4;
    localparam logic [3:0] AddrCenterY = 4'd8;

    typedef struct packed {
        logic [30:0] disk_radius;
        logic [31:0] center_x;
        logic [31:0] center_y;
    } cfg_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turns(input logic [StepBits-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[design/random_point_in_disk.sv]
// Top level: uniform random point in a disk, fully pipelined.
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_angle_draw s_distance_draw
//  m_      | out       | m_valid m_ready m_point_x m_point_y
//  apb     | in/out    | psel penable pwrite paddr pwdata prdata pready
// One item per cycle; 61 register stages: 33 square-root stages (load plus
// 32 bit steps) + 3 scaling stages + 24 CORDIC stages + 1 output stage.
// m_valid comes from the output stage, fed by the valid-bit shift register.
// Synchronous active-low reset clears the valid bits; data registers are not reset.
// Whole pipeline holds while the output register is full and not taken;
// s_ready is high whenever the pipeline advances.
module random_point_in_disk #(
    parameter int DRAW_BITS = rpd_pkg::DrawBitsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DRAW_BITS-1:0] s_angle_draw,
    input  logic [DRAW_BITS-1:0] s_distance_draw,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_point_x,
    output logic signed [31:0]   m_point_y,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rpd_pkg::*;

    localparam int SqDepth = RootBits + 1;
    localparam int Depth   = SqDepth + 3 + CordicSteps;

    cfg_t cfg;
    logic adv;
    logic [Depth-1:0] vld_reg;
    logic m_valid_reg;
    logic signed [31:0] px_reg, py_reg;

    rpd_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    // Whole pipeline moves unless output is held
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[Depth-2:0], s_valid};
    end

    // Square root; phase delayed alongside
    logic [31:0] root;
    rpd_sqrt #(.DRAW_BITS(DRAW_BITS)) u_sqrt (
        .aclk, .adv, .draw(s_distance_draw), .root
    );

    logic [31:0] ph_reg [SqDepth];
    logic [31:0] ph_in;
    assign ph_in = {s_angle_draw, {(32-DRAW_BITS){1'b0}}};
    always_ff @(posedge aclk) begin
        if (adv) begin
            ph_reg[0] <= ph_in;
            for (int k = 1; k < SqDepth; k++) ph_reg[k] <= ph_reg[k-1];
        end
    end

    // Scaling: radius*root, then gain, with quadrant fold
    logic [62:0] rr_reg;
    logic [30:0] r_reg;
    logic [62:0] g_reg;
    logic [31:0] p1_reg, p2_reg, p3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            rr_reg <= 63'(cfg.disk_radius) * 63'(root);
            p1_reg <= ph_reg[SqDepth-1];
            r_reg  <= rr_reg[62:32];
            p2_reg <= p1_reg;
            g_reg  <= 63'(r_reg) * 63'(CordicGain);
            p3_reg <= p2_reg;
        end
    end

    logic flip;
    logic [31:0] ph_f;
    logic signed [VecBits-1:0] x0;
    logic signed [ZBits-1:0]   z0;
    assign flip = p3_reg[31] ^ p3_reg[30];
    assign ph_f = flip ? (p3_reg ^ 32'h8000_0000) : p3_reg;
    assign z0   = ZBits'($signed(ph_f));
    assign x0   = $signed({13'd0, g_reg[62:24]});

    logic signed [VecBits-1:0] cx, cy;
    rpd_cordic u_cordic (
        .aclk, .adv, .x_in(x0), .z_in(z0), .flip_in(flip), .x_out(cx), .y_out(cy)
    );

    // Round to Q16.16, add centre, saturate
    function automatic logic signed [31:0] fin(input logic signed [VecBits-1:0] v,
                                               input logic signed [31:0] c);
        logic signed [VecBits:0] t;
        t = ((VecBits+1)'(v) + (VecBits+1)'(128)) >>> 8;
        t = t + (VecBits+1)'(c);
        if (t > (VecBits+1)'(64'sd2147483647))       return 32'sh7fff_ffff;
        else if (t < -(VecBits+1)'(64'sd2147483648)) return 32'sh8000_0000;
        else                                          return t[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= vld_reg[Depth-1];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= fin(cx, $signed(cfg.center_x));
            py_reg <= fin(cy, $signed(cfg.center_y));
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_point_x = px_reg;
    assign m_point_y = py_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready not tied to output drain");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[Depth-1] |=> m_valid)
        else $error("item lost at output");
`endif
endmodule

[design/rpd_regs.sv]
// Configuration registers behind an APB-style port.
module rpd_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output rpd_pkg::cfg_t cfg
);
    import rpd_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.disk_radius <= 31'd65536;
            cfg_reg.center_x    <= 32'd0;
            cfg_reg.center_y    <= 32'd0;
        end else if (wr_en) begin
            case (paddr)
                AddrRadius:  cfg_reg.disk_radius <= pwdata[30:0];
                AddrCenterX: cfg_reg.center_x    <= pwdata;
                AddrCenterY: cfg_reg.center_y    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr)
            AddrRadius:  prdata = {1'b0, cfg_reg.disk_radius};
            AddrCenterX: prdata = cfg_reg.center_x;
            AddrCenterY: prdata = cfg_reg.center_y;
            default:     prdata = 32'd0;
        endcase
    end
endmodule

[design/rpd_sqrt.sv]
// Pipelined integer square root: one result bit per stage, sqrt(u*2^64) in Q0.32 for the draw u as a fraction.
module rpd_sqrt #(
    parameter int DRAW_BITS = rpd_pkg::DrawBitsDef
) (
    input  logic                 aclk,
    input  logic                 adv,
    input  logic [DRAW_BITS-1:0] draw,
    output logic [31:0]          root
);
    import rpd_pkg::*;

    localparam int N = RootBits;

    // stage s holds remainder, partial root and the radicand bits not yet used
    logic [N+1:0]  rem_reg  [N+1];
    logic [N-1:0]  q_reg    [N+1];
    logic [2*N-1:0] rad_reg [N+1];
    logic [63:0]   rad_in;

    assign rad_in = {draw, {(64-DRAW_BITS){1'b0}}};

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            rad_reg[0] <= rad_in;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [N+1:0] trial;
        logic [N+1:0] sub;
        always_comb begin
            trial = {rem_reg[s][N-1:0], rad_reg[s][2*N-1:2*N-2]};
            sub   = {q_reg[s], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[s+1] <= {rad_reg[s][2*N-3:0], 2'b00};
                if (trial >= sub) begin
                    rem_reg[s+1] <= trial - sub;
                    q_reg[s+1]   <= {q_reg[s][N-2:0], 1'b1};
                end else begin
                    rem_reg[s+1] <= trial;
                    q_reg[s+1]   <= {q_reg[s][N-2:0], 1'b0};
                end
            end
        end
    end

    assign root = q_reg[N];
endmodule

[design/rpd_cordic.sv]
// Pipelined rotation-mode CORDIC, one iteration per stage, quadrant fold at output.
module rpd_cordic (
    input  logic                           aclk,
    input  logic                           adv,
    input  logic signed [rpd_pkg::VecBits-1:0] x_in,
    input  logic signed [rpd_pkg::ZBits-1:0]   z_in,
    input  logic                           flip_in,
    output logic signed [rpd_pkg::VecBits-1:0] x_out,
    output logic signed [rpd_pkg::VecBits-1:0] y_out
);
    import rpd_pkg::*;

    logic signed [VecBits-1:0] x_reg [CordicSteps+1];
    logic signed [VecBits-1:0] y_reg [CordicSteps+1];
    logic signed [ZBits-1:0]   z_reg [CordicSteps+1];
    logic                      f_reg [CordicSteps+1];

    always_comb begin
        x_reg[0] = x_in;
        y_reg[0] = '0;
        z_reg[0] = z_in;
        f_reg[0] = flip_in;
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_it
        logic signed [VecBits-1:0] dx;
        logic signed [VecBits-1:0] dy;
        logic signed [ZBits-1:0]   at;
        always_comb begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            at = $signed({2'b00, atan_turns(StepBits'(i))});
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][ZBits-1]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    assign x_out = f_reg[CordicSteps] ? -x_reg[CordicSteps] : x_reg[CordicSteps];
    assign y_out = f_reg[CordicSteps] ? -y_reg[CordicSteps] : y_reg[CordicSteps];
endmodule

[test/testbench.sv]
// Testbench for random_point_in_disk: directed table plus random draws, checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import rpd_pkg::*;

    localparam int NumPhases   = 7;
    localparam int PhaseItems  = 240;
    localparam int DrainCycles = 70;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] AtanTurns [CordicSteps] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] distance;
        logic        typed;
        logic [31:0] px;
        logic [31:0] py;
    } draw_row_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
    } point_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_angle_draw;
    logic [15:0] s_distance_draw;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_point_x;
    logic signed [31:0] m_point_y;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Testbench copy of the registers
    logic [30:0] disk_radius_q;
    logic [31:0] center_x_q;
    logic [31:0] center_y_q;

    // Sideband of the item on the input channel: typed expectation, if any
    logic        cur_typed;
    logic [31:0] cur_px;
    logic [31:0] cur_py;

    logic        idle_on;
    int          errors;
    point_t      points_due[$];

    random_point_in_disk uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_angle_draw(s_angle_draw), .s_distance_draw(s_distance_draw),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(4ns * 2000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // floor(sqrt(v)), bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem = v;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Round Q16.24 to Q16.16, add centre, saturate
    function automatic logic [31:0] to_coord(input longint v, input logic [31:0] centre);
        longint s;
        s = ((v + 128) >>> 8) + longint'(signed'(centre));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic point_t disk_point(input logic [15:0] angle, input logic [15:0] distance);
        logic [63:0] root;
        logic [63:0] dist_q16;
        logic [31:0] phase;
        logic        flip;
        longint      x, y, z, dx, dy;
        point_t      p;
        root = floor_sqrt({distance, 48'd0});
        dist_q16 = ({33'd0, disk_radius_q} * root) >> 32;
        phase = {angle, 16'd0};
        flip = phase[31] ^ phase[30];
        if (flip) phase = phase ^ 32'h8000_0000;
        z = longint'(signed'(phase));
        x = longint'((dist_q16 * {32'd0, CordicGain}) >> 24);
        y = 0;
        for (int i = 0; i < CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(AtanTurns[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(AtanTurns[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        p.px = to_coord(x, center_x_q);
        p.py = to_coord(y, center_y_q);
        return p;
    endfunction

    // Register write, then read back
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        logic [31:0] want;
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;
        case (addr)
            AddrRadius:  disk_radius_q = data[30:0];
            AddrCenterX: center_x_q = data;
            default:     center_y_q = data;
        endcase
        want = (addr == AddrRadius) ? {1'b0, data[30:0]} : data;
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) report("register read", prdata, want);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    task automatic send_draw(input draw_row_t row);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_angle_draw <= row.angle;
        s_distance_draw <= row.distance;
        cur_typed <= row.typed;
        cur_px <= row.px;
        cur_py <= row.py;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain;
        int guard;
        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (points_due.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    function automatic logic [15:0] rand_draw;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 1) - 1);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Input transfers make predictions, output transfers are checked
    always @(posedge aclk) begin
        point_t p;
        point_t want;
        if (aresetn && s_valid && s_ready) begin
            p = disk_point(s_angle_draw, s_distance_draw);
            if (cur_typed) begin
                p.px = cur_px;
                p.py = cur_py;
            end
            points_due.push_back(p);
        end
        if (aresetn && m_valid && m_ready) begin
            if (points_due.size() == 0) begin
                report("unexpected point_x", m_point_x, 32'd0);
            end else begin
                want = points_due.pop_front();
                if (m_point_x !== want.px) report("point_x", m_point_x, want.px);
                if (m_point_y !== want.py) report("point_y", m_point_y, want.py);
            end
        end
    end

    // Receiver stalls
    always @(negedge aclk) begin
        m_ready <= !(idle_on && $urandom_range(0, 99) < 8);
    end

    initial begin
        draw_row_t table_rows [$];
        draw_row_t row;
        logic [31:0] radius_v, cx_v, cy_v;

        errors = 0;
        idle_on = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_angle_draw = '0;
        s_distance_draw = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cur_typed = 1'b0; cur_px = '0; cur_py = '0;
        disk_radius_q = 31'd65536;
        center_x_q = '0;
        center_y_q = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // Directed: zero distance lands on the centre, quadrant edges, full-scale draws
        table_rows = '{
            '{16'h0000, 16'h0000, 1'b1, 32'd0, 32'd0},
            '{16'hFFFF, 16'h0000, 1'b1, 32'd0, 32'd0},
            '{16'h8000, 16'h0000, 1'b1, 32'd0, 32'd0},
            '{16'h0000, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'h3FFF, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'h4000, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'h7FFF, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'h8000, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'hBFFF, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'hC000, 16'hFFFF, 1'b0, 32'd0, 32'd0},
            '{16'h2000, 16'h4000, 1'b0, 32'd0, 32'd0},
            '{16'hAAAA, 16'h5555, 1'b0, 32'd0, 32'd0},
            '{16'h5555, 16'hAAAA, 1'b0, 32'd0, 32'd0},
            '{16'h0001, 16'h0001, 1'b0, 32'd0, 32'd0},
            '{16'h6000, 16'h8000, 1'b0, 32'd0, 32'd0}
        };
        foreach (table_rows[i]) send_draw(table_rows[i]);
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: begin radius_v = 32'h7FFF_FFFF; cx_v = 32'h7FFF_FFFF; cy_v = 32'h8000_0000; end
                1: begin radius_v = 32'h0000_0000; cx_v = $urandom; cy_v = $urandom; end
                2: begin radius_v = 32'h7FFF_FFFF; cx_v = 32'h8000_0000; cy_v = 32'h7FFF_FFFF; end
                3: begin radius_v = 32'h0000_0001; cx_v = 32'd0; cy_v = 32'd0; end
                4: begin radius_v = 32'hFFFF_FFFF; cx_v = 32'd0; cy_v = 32'd0; end
                default: begin
                    radius_v = $urandom_range(0, 32'h00FF_FFFF);
                    cx_v = $urandom;
                    cy_v = $urandom;
                end
            endcase
            reg_write(AddrRadius, radius_v);
            reg_write(AddrCenterX, cx_v);
            reg_write(AddrCenterY, cy_v);
            // one phase runs with no idling on either side
            idle_on = (ph != 3);
            for (int n = 0; n < PhaseItems; n++) begin
                row.angle = rand_draw();
                row.distance = rand_draw();
                row.typed = 1'b0;
                row.px = '0;
                row.py = '0;
                send_draw(row);
            end
            drain();
        end

        repeat (DrainCycles) @(posedge aclk);
        if (points_due.size() != 0) report("missing points", 32'(points_due.size()), 32'd0);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
